// File: src/wlsb_pkg.sv
// ----------------------------------------------------------------------------
// wlsb_pkg
// Types and constants shared by the weight limited stack bank.
// ----------------------------------------------------------------------------
`default_nettype none

package wlsb_pkg;

	localparam int STACKS = 4;
	localparam int SLOTS = 3;
	localparam int ENTRIES = STACKS * SLOTS;

	localparam int VALUE_W = 32;
	localparam int WEIGHT_W = 16;
	localparam int SEL_W = 2;
	localparam int STATUS_W = 2;
	localparam int DEPTH_OUT_W = 2;

	localparam int DEPTH_W = $clog2(SLOTS + 1);
	localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int WORD_W = WEIGHT_W + VALUE_W;

	localparam logic [WEIGHT_W-1:0] MAX_WEIGHT_RST = 16'd50;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_HEAVY = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef struct packed {
		op_t                        op;
		logic [SEL_W-1:0]           stack_sel;
		logic signed [VALUE_W-1:0]  value;
		logic [WEIGHT_W-1:0]        weight;
	} item_t;

	typedef struct packed {
		status_t                    status;
		logic signed [VALUE_W-1:0]  popped_value;
		logic [DEPTH_OUT_W-1:0]     depth_after;
		logic [WEIGHT_W-1:0]        weight_after;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic commit;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
	} dp_sts_t;

endpackage

`default_nettype wire

// File: src/wlsb_ram.sv
// ----------------------------------------------------------------------------
// wlsb_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wlsb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: src/wlsb_ctrl.sv
// ----------------------------------------------------------------------------
// wlsb_ctrl
// Sequencer: takes one access, lets the entry read settle, then commits.
// ----------------------------------------------------------------------------
`default_nettype none

module wlsb_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 item_valid,
	output logic                      item_stall,
	input  wire wlsb_pkg::dp_sts_t    sts,
	output wlsb_pkg::ctrl_cmd_t       cmd
);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;

	assign item_stall = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: cmd.load = item_valid;
			S_EXEC: cmd.commit = sts.out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					// hold until the result register can take the beat
					if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: src/wlsb_dp.sv
// ----------------------------------------------------------------------------
// wlsb_dp
// Datapath: per-stack depth and weight totals, item store, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wlsb_dp (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire wlsb_pkg::ctrl_cmd_t                   cmd,
	output wlsb_pkg::dp_sts_t                          sts,
	input  wire wlsb_pkg::item_t                       item,
	input  wire logic                                  cfg_valid,
	input  wire logic [wlsb_pkg::WEIGHT_W-1:0]         cfg_data,
	output logic                                       result_valid,
	input  wire logic                                  result_stall,
	output wlsb_pkg::result_t                          result
);

	logic [wlsb_pkg::WEIGHT_W-1:0] max_weight_q;
	logic [wlsb_pkg::DEPTH_W-1:0]  depth_q [wlsb_pkg::STACKS];
	logic [wlsb_pkg::WEIGHT_W-1:0] wsum_q  [wlsb_pkg::STACKS];

	wlsb_pkg::item_t  item_q;
	wlsb_pkg::result_t result_q;
	logic              result_valid_q;

	// load side
	logic                          ld_present;
	logic [wlsb_pkg::DEPTH_W-1:0]  ld_depth;
	logic [wlsb_pkg::ADDR_W-1:0]   ld_base;
	logic [wlsb_pkg::ADDR_W-1:0]   rd_addr;

	// execute side
	logic                          cur_present;
	logic [wlsb_pkg::DEPTH_W-1:0]  cur_depth;
	logic [wlsb_pkg::WEIGHT_W-1:0] cur_wsum;
	logic [wlsb_pkg::ADDR_W-1:0]   cur_base;
	logic [wlsb_pkg::WEIGHT_W:0]   sum;
	logic [wlsb_pkg::WORD_W-1:0]   rd_word;
	logic [wlsb_pkg::WEIGHT_W-1:0] rd_weight;
	logic [wlsb_pkg::VALUE_W-1:0]  rd_value;

	wlsb_pkg::status_t             nxt_status;
	logic [wlsb_pkg::DEPTH_W-1:0]  nxt_depth;
	logic [wlsb_pkg::WEIGHT_W-1:0] nxt_wsum;
	logic [wlsb_pkg::VALUE_W-1:0]  nxt_popped;
	logic                          push_ok;
	logic                          upd;

	assign sts.out_free = !result_valid_q || !result_stall;
	assign result_valid = result_valid_q;
	assign result = result_q;

	// read address for the top entry of the addressed stack
	always_comb begin
		ld_present = (int'(item.stack_sel) < wlsb_pkg::STACKS);
		ld_depth = ld_present ? depth_q[item.stack_sel] : '0;
		ld_base = ld_present
			? wlsb_pkg::ADDR_W'(item.stack_sel) * wlsb_pkg::ADDR_W'(wlsb_pkg::SLOTS) : '0;
		rd_addr = (ld_depth == '0)
			? ld_base : ld_base + wlsb_pkg::ADDR_W'(ld_depth - 1'b1);
	end

	assign rd_value = rd_word[wlsb_pkg::VALUE_W-1:0];
	assign rd_weight = rd_word[wlsb_pkg::WORD_W-1:wlsb_pkg::VALUE_W];

	always_comb begin
		cur_present = (int'(item_q.stack_sel) < wlsb_pkg::STACKS);
		cur_depth = cur_present ? depth_q[item_q.stack_sel] : '0;
		cur_wsum = cur_present ? wsum_q[item_q.stack_sel] : '0;
		cur_base = cur_present
			? wlsb_pkg::ADDR_W'(item_q.stack_sel) * wlsb_pkg::ADDR_W'(wlsb_pkg::SLOTS) : '0;
		sum = {1'b0, cur_wsum} + {1'b0, item_q.weight};

		nxt_status = wlsb_pkg::ST_DONE;
		nxt_depth = cur_depth;
		nxt_wsum = cur_wsum;
		nxt_popped = '0;
		push_ok = 1'b0;
		upd = 1'b0;

		if (!cur_present) begin
			// missing stack: full for a push, empty for a pop
			nxt_status = (item_q.op == wlsb_pkg::OP_PUSH) ? wlsb_pkg::ST_FULL
				: wlsb_pkg::ST_EMPTY;
		end else if (item_q.op == wlsb_pkg::OP_PUSH) begin
			if (cur_depth >= wlsb_pkg::DEPTH_W'(wlsb_pkg::SLOTS)) begin
				nxt_status = wlsb_pkg::ST_FULL;
			end else if (sum > {1'b0, max_weight_q}) begin
				nxt_status = wlsb_pkg::ST_HEAVY;
			end else begin
				push_ok = 1'b1;
				upd = 1'b1;
				nxt_depth = cur_depth + 1'b1;
				nxt_wsum = sum[wlsb_pkg::WEIGHT_W-1:0];
			end
		end else begin
			if (cur_depth == '0) begin
				nxt_status = wlsb_pkg::ST_EMPTY;
			end else begin
				upd = 1'b1;
				nxt_popped = rd_value;
				nxt_depth = cur_depth - 1'b1;
				nxt_wsum = cur_wsum - rd_weight;
			end
		end
	end

	wlsb_ram #(
		.WIDTH (wlsb_pkg::WORD_W),
		.DEPTH (wlsb_pkg::ENTRIES)
	) u_items (
		.clk   (clk),
		.we    (cmd.commit && push_ok),
		.waddr (cur_base + wlsb_pkg::ADDR_W'(cur_depth)),
		.wdata ({item_q.weight, item_q.value}),
		.re    (cmd.load),
		.raddr (rd_addr),
		.rdata (rd_word)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (cmd.commit) begin
			result_q.status <= nxt_status;
			result_q.popped_value <= nxt_popped;
			result_q.depth_after <= wlsb_pkg::DEPTH_OUT_W'(nxt_depth);
			result_q.weight_after <= nxt_wsum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_weight_q <= wlsb_pkg::MAX_WEIGHT_RST;
			result_valid_q <= 1'b0;
			for (int i = 0; i < wlsb_pkg::STACKS; i++) begin
				depth_q[i] <= '0;
				wsum_q[i] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				max_weight_q <= cfg_data;
			end
			if (cmd.commit) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			if (cmd.commit && upd) begin
				depth_q[item_q.stack_sel] <= nxt_depth;
				wsum_q[item_q.stack_sel] <= nxt_wsum;
			end
		end
	end

endmodule

`default_nettype wire

// File: src/weight_limited_stack_bank_top.sv
// ----------------------------------------------------------------------------
// weight_limited_stack_bank_top
// Bank of small LIFO stacks with a per-stack weight budget.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid / item_stall / item): one push or pop per beat.
//   result channel (result_valid / result_stall / result): one beat per item,
//   carrying status, popped value and the stack's depth and weight after it.
//   cfg channel (cfg_valid / cfg_ready / cfg_data): writes max_weight; always
//   ready, write only while no access is in flight.
// Order: a taken item and its stack's top entry read are registered, then the
//   commit step registers its result beat. The next item is taken only after
//   that commit, set by the registered read of the item store before it.
// The result register decouples the two sides: the next item is accepted
//   while a result still waits. If result_stall holds, the following item
//   waits in the commit step and item_stall stays high.
// Reset: all stacks empty with zero weight, max_weight = 50, no result
//   pending. Item store contents are left as they are.
// ----------------------------------------------------------------------------
`default_nettype none

module weight_limited_stack_bank_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid,
	output logic                               item_stall,
	input  wire wlsb_pkg::item_t               item,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output wlsb_pkg::result_t                  result,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [wlsb_pkg::WEIGHT_W-1:0] cfg_data
);

	wlsb_pkg::ctrl_cmd_t cmd;
	wlsb_pkg::dp_sts_t   sts;

	assign cfg_ready = 1'b1;

	wlsb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	wlsb_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.item         (item),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire
